/* hdl/lcr_pkg.sv */
// shared constants, types and tables for the led color ramp
`default_nettype none

package lcr_pkg;

    // field widths
    localparam int COLOR_W    = 8;
    localparam int PERIOD_W   = 16;
    localparam int SEG_W      = 14;
    localparam int FADE_W     = 8;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int NUM_CH     = 3;

    // divider sizes: numerator is q * |delta|, denominator a length
    localparam int QUOT_W = SEG_W + COLOR_W;
    localparam int DEN_W  = SEG_W;

    // commands
    localparam logic [CMD_W-1:0] CMD_SUNRISE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SUNSET  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ON      = 2'd2;
    localparam logic [CMD_W-1:0] CMD_OFF     = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_GREEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BLUE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEG_LEN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_LEN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_IN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_OUT  = 3'd6;

    // register reset values
    localparam logic [COLOR_W-1:0]  MAX_RESET      = 8'd150;
    localparam logic [SEG_W-1:0]    SEG_RESET      = 14'd450;
    localparam logic [PERIOD_W-1:0] TOTAL_RESET    = 16'd1800;
    localparam logic [FADE_W-1:0]   FADE_IN_RESET  = 8'd20;
    localparam logic [FADE_W-1:0]   FADE_OUT_RESET = 8'd20;

    // first period of the sunset hold
    localparam int HOLD_START = 3;

    typedef logic [COLOR_W-1:0] color_t;

    typedef struct packed {
        color_t                max_red;
        color_t                max_green;
        color_t                max_blue;
        logic [SEG_W-1:0]      seg_len;
        logic [PERIOD_W-1:0]   total_len;
        logic [FADE_W-1:0]     fade_in_len;
        logic [FADE_W-1:0]     fade_out_len;
    } cfg_t;

    // sunrise knots per segment start, red / green / blue
    localparam color_t SR_KNOT [4][NUM_CH] = '{
        '{8'd0,   8'd0,  8'd0},
        '{8'd20,  8'd2,  8'd0},
        '{8'd50,  8'd20, 8'd0},
        '{8'd127, 8'd51, 8'd11}
    };

endpackage

`default_nettype wire

/* hdl/led_color_ramp.sv */
// top level of the led color ramp: sequencer, shared multiply and divide
//
// Input channel (in_valid / in_ready) takes one beat of command and period;
// output channel (out_valid / out_ready) returns one beat of red, green and
// blue for every input beat. Registers are written through cfg_write,
// cfg_index and cfg_data, one per cycle; the user must write them only
// while no beat is in flight, as the block itself does not enforce it. Sunrise
// steps and sunset fades run one multiply and one divide per color channel:
// a setup state, then per channel a multiply, a divider start, 22 divider
// steps, a wait for done and an accumulate, then a push state. Maxima, on,
// off, hold and black beats go from setup straight to the push. The serial
// divider is shared by the three channels. in_ready is high only while the
// sequencer is idle, from the cycle after the push, so no new beat is
// taken before the push. The finished color sits in an output register, so
// a new beat is taken while the previous result waits for out_ready; if the
// receiver stalls longer, the sequencer holds its result until the output
// register frees up. Reset clears the shown and captured colors to black,
// restores register defaults and leaves the output channel empty.
`default_nettype none

module led_color_ramp (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [lcr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lcr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [lcr_pkg::CMD_W-1:0]      command,
    input  wire logic [lcr_pkg::PERIOD_W-1:0]   period,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [lcr_pkg::COLOR_W-1:0]         red,
    output logic [lcr_pkg::COLOR_W-1:0]         green,
    output logic [lcr_pkg::COLOR_W-1:0]         blue
);

    localparam int NUM_CH   = lcr_pkg::NUM_CH;
    localparam int COLOR_W  = lcr_pkg::COLOR_W;
    localparam int PERIOD_W = lcr_pkg::PERIOD_W;
    localparam int SEG_W    = lcr_pkg::SEG_W;
    localparam int FADE_W   = lcr_pkg::FADE_W;
    localparam int QUOT_W   = lcr_pkg::QUOT_W;
    localparam int ACC_W    = QUOT_W + 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_ACC,
        ST_PUSH
    } state_t;

    state_t state_reg;
    state_t state_next;

    lcr_pkg::cfg_t cfg;

    // accepted beat
    logic [lcr_pkg::CMD_W-1:0] cmd_reg;
    logic [PERIOD_W-1:0]       per_reg;

    // color state
    lcr_pkg::color_t shown_reg [NUM_CH];
    lcr_pkg::color_t start_reg [NUM_CH];

    // job for the shared unit
    lcr_pkg::color_t  job_base_reg [NUM_CH];
    lcr_pkg::color_t  job_dmag_reg [NUM_CH];
    logic             job_dneg_reg [NUM_CH];
    logic [SEG_W-1:0] job_q_reg;
    logic [SEG_W-1:0] job_den_reg;
    lcr_pkg::color_t  color_reg [NUM_CH];
    logic [1:0]       ch_reg;
    logic [QUOT_W-1:0] prod_reg;

    // output register
    logic            out_valid_reg;
    lcr_pkg::color_t red_reg;
    lcr_pkg::color_t green_reg;
    lcr_pkg::color_t blue_reg;

    // setup decode
    lcr_pkg::color_t   max_c [NUM_CH];
    lcr_pkg::color_t   start_src [NUM_CH];
    logic [SEG_W-1:0]  sr_len;
    logic [PERIOD_W-1:0] sr_len1;
    logic [PERIOD_W-1:0] sr_len2;
    logic [PERIOD_W-1:0] sr_len3;
    logic [PERIOD_W-1:0] sr_len4;
    logic [PERIOD_W-1:0] sr_off;
    logic [PERIOD_W-1:0] sr_q;
    logic [1:0]          sr_seg;
    logic                sr_over;
    logic [FADE_W-1:0]   ss_fin;
    logic [FADE_W-1:0]   ss_fout;
    logic [PERIOD_W-1:0] ss_total;
    logic signed [PERIOD_W:0] ss_tmo;
    logic signed [PERIOD_W:0] ss_p;
    logic signed [PERIOD_W:0] ss_k;
    logic              su_lerp;
    lcr_pkg::color_t   su_base [NUM_CH];
    lcr_pkg::color_t   su_tgt [NUM_CH];
    lcr_pkg::color_t   su_fixed [NUM_CH];
    lcr_pkg::color_t   su_dmag [NUM_CH];
    logic              su_dneg [NUM_CH];
    logic [COLOR_W:0]  su_d9;
    logic [SEG_W-1:0]  su_q;
    logic [SEG_W-1:0]  su_den;

    // accumulate
    logic                    div_start;
    logic                    div_done;
    logic [QUOT_W-1:0]       div_quot;
    logic signed [ACC_W-1:0] acc_base;
    logic signed [ACC_W-1:0] acc_quot;
    logic signed [ACC_W-1:0] acc_sum;
    lcr_pkg::color_t         acc_clamped;

    logic push_fire;

    lcr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lcr_div #(
        .NUM_W (QUOT_W),
        .DEN_W (lcr_pkg::DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (prod_reg),
        .den   (job_den_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // zero lengths count as one
    always_comb
    begin
        max_c[0] = cfg.max_red;
        max_c[1] = cfg.max_green;
        max_c[2] = cfg.max_blue;
        sr_len   = (cfg.seg_len == '0) ? SEG_W'(1) : cfg.seg_len;
        ss_fin   = (cfg.fade_in_len == '0) ? FADE_W'(1) : cfg.fade_in_len;
        ss_fout  = (cfg.fade_out_len == '0) ? FADE_W'(1) : cfg.fade_out_len;
        ss_total = (cfg.total_len == '0) ? PERIOD_W'(1) : cfg.total_len;
    end

    // sunrise segment search
    always_comb
    begin
        sr_len1 = PERIOD_W'(sr_len);
        sr_len2 = PERIOD_W'({sr_len, 1'b0});
        sr_len4 = PERIOD_W'({sr_len, 2'b00});
        sr_len3 = sr_len1 + sr_len2;
        sr_over = 1'b0;
        priority if (per_reg < sr_len1)
        begin
            sr_seg = 2'd0;
            sr_off = '0;
        end
        else if (per_reg < sr_len2)
        begin
            sr_seg = 2'd1;
            sr_off = sr_len1;
        end
        else if (per_reg < sr_len3)
        begin
            sr_seg = 2'd2;
            sr_off = sr_len2;
        end
        else if (per_reg < sr_len4)
        begin
            sr_seg = 2'd3;
            sr_off = sr_len3;
        end
        else
        begin
            sr_seg  = 2'd3;
            sr_off  = sr_len3;
            sr_over = 1'b1;
        end
        sr_q = per_reg - sr_off + PERIOD_W'(1);
    end

    // sunset windows, signed since fade-out may exceed the total
    always_comb
    begin
        ss_tmo = $signed({1'b0, ss_total}) - $signed({{(PERIOD_W + 1 - FADE_W){1'b0}}, ss_fout});
        ss_p   = $signed({1'b0, per_reg});
        ss_k   = ss_p - ss_tmo + $signed((PERIOD_W + 1)'(1));
        for (int c = 0; c < NUM_CH; c++)
        begin
            start_src[c] = (per_reg == '0) ? shown_reg[c] : start_reg[c];
        end
    end

    // job setup per command
    always_comb
    begin
        su_lerp = 1'b0;
        su_q    = '0;
        su_den  = SEG_W'(1);
        for (int c = 0; c < NUM_CH; c++)
        begin
            su_base[c]  = '0;
            su_tgt[c]   = '0;
            su_fixed[c] = '0;
        end
        unique case (cmd_reg)
            lcr_pkg::CMD_SUNRISE:
            begin
                if (sr_over)
                begin
                    su_fixed = max_c;
                end
                else
                begin
                    su_lerp = 1'b1;
                    su_q    = sr_q[SEG_W-1:0];
                    su_den  = sr_len;
                    for (int c = 0; c < NUM_CH; c++)
                    begin
                        su_base[c] = lcr_pkg::SR_KNOT[sr_seg][c];
                        su_tgt[c]  = (sr_seg == 2'd3) ? max_c[c]
                                                      : lcr_pkg::SR_KNOT[sr_seg + 2'd1][c];
                    end
                end
            end
            lcr_pkg::CMD_SUNSET:
            begin
                priority if (per_reg < PERIOD_W'(ss_fin))
                begin
                    su_lerp = 1'b1;
                    su_q    = SEG_W'(per_reg[FADE_W-1:0]) + SEG_W'(1);
                    su_den  = SEG_W'(ss_fin);
                    su_base = start_src;
                    su_tgt  = max_c;
                end
                else if (per_reg >= PERIOD_W'(lcr_pkg::HOLD_START) && ss_p <= ss_tmo)
                begin
                    su_fixed = max_c;
                end
                else if (ss_p >= ss_tmo && per_reg < ss_total)
                begin
                    su_lerp = 1'b1;
                    su_q    = ss_k[SEG_W-1:0];
                    su_den  = SEG_W'(ss_fout);
                    su_base = max_c;
                end
                else
                begin
                    su_lerp = 1'b0;
                end
            end
            lcr_pkg::CMD_ON:
            begin
                su_fixed = max_c;
            end
            lcr_pkg::CMD_OFF:
            begin
                su_lerp = 1'b0;
            end
        endcase
        // split each delta into sign and magnitude
        su_d9 = '0;
        for (int c = 0; c < NUM_CH; c++)
        begin
            su_d9      = {1'b0, su_tgt[c]} - {1'b0, su_base[c]};
            su_dneg[c] = su_d9[COLOR_W];
            su_dmag[c] = su_d9[COLOR_W] ? COLOR_W'(-su_d9) : su_d9[COLOR_W-1:0];
        end
    end

    // base plus or minus quotient, clamped to a color level
    always_comb
    begin
        acc_base = $signed({{(ACC_W - COLOR_W){1'b0}}, job_base_reg[ch_reg]});
        acc_quot = $signed({2'b00, div_quot});
        acc_sum  = job_dneg_reg[ch_reg] ? (acc_base - acc_quot) : (acc_base + acc_quot);
        priority if (acc_sum < 0)
        begin
            acc_clamped = '0;
        end
        else if (acc_sum > $signed(ACC_W'(255)))
        begin
            acc_clamped = '1;
        end
        else
        begin
            acc_clamped = acc_sum[COLOR_W-1:0];
        end
    end

    assign div_start = (state_reg == ST_DIV_GO);
    assign push_fire = (state_reg == ST_PUSH) && (!out_valid_reg || out_ready);

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    state_next = ST_SETUP;
                end
            ST_SETUP:
                state_next = su_lerp ? ST_MUL : ST_PUSH;
            ST_MUL:
                state_next = ST_DIV_GO;
            ST_DIV_GO:
                state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
                if (div_done)
                begin
                    state_next = ST_ACC;
                end
            ST_ACC:
                state_next = (ch_reg == 2'(NUM_CH - 1)) ? ST_PUSH : ST_MUL;
            ST_PUSH:
                if (push_fire)
                begin
                    state_next = ST_IDLE;
                end
        endcase
    end

    // state, color state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            red_reg       <= '0;
            green_reg     <= '0;
            blue_reg      <= '0;
            for (int c = 0; c < NUM_CH; c++)
            begin
                shown_reg[c] <= '0;
                start_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_SETUP && cmd_reg == lcr_pkg::CMD_SUNSET && per_reg == '0)
            begin
                start_reg <= shown_reg;
            end
            if (push_fire)
            begin
                out_valid_reg <= 1'b1;
                red_reg       <= color_reg[0];
                green_reg     <= color_reg[1];
                blue_reg      <= color_reg[2];
                shown_reg     <= color_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    cmd_reg <= command;
                    per_reg <= period;
                end
            ST_SETUP:
            begin
                job_base_reg <= su_base;
                job_dmag_reg <= su_dmag;
                job_dneg_reg <= su_dneg;
                job_q_reg    <= su_q;
                job_den_reg  <= su_den;
                color_reg    <= su_fixed;
                ch_reg       <= '0;
            end
            ST_MUL:
                prod_reg <= QUOT_W'(job_q_reg) * QUOT_W'(job_dmag_reg[ch_reg]);
            ST_ACC:
            begin
                color_reg[ch_reg] <= acc_clamped;
                ch_reg            <= ch_reg + 2'd1;
            end
            ST_DIV_GO, ST_DIV_WAIT, ST_PUSH:
            begin
            end
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

`default_nettype wire

/* hdl/lcr_cfg.sv */
// configuration register file of the led color ramp
`default_nettype none

module lcr_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [lcr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lcr_pkg::CFG_DATA_W-1:0] cfg_data,
    output lcr_pkg::cfg_t                       cfg
);

    lcr_pkg::cfg_t cfg_reg;

    // register writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_red      <= lcr_pkg::MAX_RESET;
            cfg_reg.max_green    <= lcr_pkg::MAX_RESET;
            cfg_reg.max_blue     <= lcr_pkg::MAX_RESET;
            cfg_reg.seg_len      <= lcr_pkg::SEG_RESET;
            cfg_reg.total_len    <= lcr_pkg::TOTAL_RESET;
            cfg_reg.fade_in_len  <= lcr_pkg::FADE_IN_RESET;
            cfg_reg.fade_out_len <= lcr_pkg::FADE_OUT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                lcr_pkg::REG_MAX_RED:
                    cfg_reg.max_red <= cfg_data[lcr_pkg::COLOR_W-1:0];
                lcr_pkg::REG_MAX_GREEN:
                    cfg_reg.max_green <= cfg_data[lcr_pkg::COLOR_W-1:0];
                lcr_pkg::REG_MAX_BLUE:
                    cfg_reg.max_blue <= cfg_data[lcr_pkg::COLOR_W-1:0];
                lcr_pkg::REG_SEG_LEN:
                    cfg_reg.seg_len <= cfg_data[lcr_pkg::SEG_W-1:0];
                lcr_pkg::REG_TOTAL_LEN:
                    cfg_reg.total_len <= cfg_data[lcr_pkg::PERIOD_W-1:0];
                lcr_pkg::REG_FADE_IN:
                    cfg_reg.fade_in_len <= cfg_data[lcr_pkg::FADE_W-1:0];
                lcr_pkg::REG_FADE_OUT:
                    cfg_reg.fade_out_len <= cfg_data[lcr_pkg::FADE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* hdl/lcr_div.sv */
// restoring serial divider, one quotient bit per cycle
`default_nettype none

module lcr_div #(
    parameter int NUM_W = lcr_pkg::QUOT_W,
    parameter int DEN_W = lcr_pkg::DEN_W
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic [NUM_W-1:0]      quot
);

    localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic [NUM_W-1:0] work_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    // trial subtract of the shifted remainder
    assign trial = {rem_reg, work_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= num;
            rem_reg  <= '0;
            den_reg  <= den;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            work_reg <= {work_reg[NUM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = work_reg;

endmodule

`default_nettype wire

/* hdl/lcr_checker.sv */
// port-level checks of the led color ramp, bound to the top level
`default_nettype none

module lcr_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_ready,
    input wire logic [lcr_pkg::CMD_W-1:0]      command,
    input wire logic                           out_valid,
    input wire logic                           out_ready,
    input wire logic [lcr_pkg::COLOR_W-1:0]    red,
    input wire logic [lcr_pkg::COLOR_W-1:0]    green,
    input wire logic [lcr_pkg::COLOR_W-1:0]    blue
);

    // one beat in work at a time
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready
    ) else $error("input taken again right after an accepted beat");

    // a result only appears out of a busy sequencer
    a_result_from_work: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready)
    ) else $error("result appeared without a beat in work");

    // stalled result holds
    a_out_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green) && $stable(blue)
    ) else $error("stalled result changed or dropped");

    // off goes straight to black
    a_off_black: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid && command == lcr_pkg::CMD_OFF
        |=> ##2 out_valid && red == '0 && green == '0 && blue == '0
    ) else $error("off command did not give black in time");

endmodule

bind led_color_ramp lcr_checker u_lcr_checker (.*);

`default_nettype wire

/* tb/led_color_ramp_checker.sv */
// checker for the led color ramp: predicts every color beat and compares it
module led_color_ramp_checker
    import lcr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [CMD_W-1:0]      command,
    input  logic [PERIOD_W-1:0]   period,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [COLOR_W-1:0]    red,
    input  logic [COLOR_W-1:0]    green,
    input  logic [COLOR_W-1:0]    blue,
    output int                    fail_count,
    output int                    beats_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        color_t red;
        color_t green;
        color_t blue;
    } rgb_t;

    // sunrise levels at the start of each segment, red / green / blue
    localparam int DAWN_KNOT [4][NUM_CH] = '{
        '{0,   0,  0},
        '{20,  2,  0},
        '{50,  20, 0},
        '{127, 51, 11}
    };

    cfg_t settings;
    rgb_t shown;
    rgb_t dusk_start;
    rgb_t color_q [$];
    rgb_t got_color;
    rgb_t want_color;
    int   bad_beats;

    function automatic int at_least_one(input int v);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic color_t saturate(input int v);
        if (v < 0)
            return '0;
        if (v > 255)
            return 8'd255;
        return color_t'(v);
    endfunction

    // base + q * (target - base) / len, signed, truncated toward zero
    function automatic color_t blend(input int base, input int target, input int q,
                                     input int len);
        return saturate(base + (q * (target - base)) / len);
    endfunction

    function automatic int peak(input int ch);
        case (ch)
            0:       return int'(settings.max_red);
            1:       return int'(settings.max_green);
            default: return int'(settings.max_blue);
        endcase
    endfunction

    function automatic rgb_t full_color();
        return '{red: settings.max_red, green: settings.max_green, blue: settings.max_blue};
    endfunction

    // four linear segments, then the maxima
    function automatic rgb_t dawn_color(input int p);
        int     len;
        int     seg;
        int     q;
        int     goal;
        color_t lvl [NUM_CH];
        len = at_least_one(int'(settings.seg_len));
        if (p >= 4 * len)
            return full_color();
        seg = p / len;
        q = p - seg * len + 1;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            if (seg == 3)
                goal = peak(ch);
            else
                goal = DAWN_KNOT[seg + 1][ch];
            lvl[ch] = blend(DAWN_KNOT[seg][ch], goal, q, len);
        end
        return '{red: lvl[0], green: lvl[1], blue: lvl[2]};
    endfunction

    // fade in from the captured color, hold, fade out, then black
    function automatic rgb_t dusk_color(input int p);
        int     fin;
        int     fout;
        int     total;
        int     k;
        int     from;
        color_t lvl [NUM_CH];
        fin = at_least_one(int'(settings.fade_in_len));
        fout = at_least_one(int'(settings.fade_out_len));
        total = at_least_one(int'(settings.total_len));
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            case (ch)
                0:       from = int'(dusk_start.red);
                1:       from = int'(dusk_start.green);
                default: from = int'(dusk_start.blue);
            endcase
            if (p < fin)
                lvl[ch] = blend(from, peak(ch), p + 1, fin);
            else if (p >= HOLD_START && p <= total - fout)
                lvl[ch] = color_t'(peak(ch));
            else if (p >= total - fout && p < total)
            begin
                k = p - total + fout + 1;
                lvl[ch] = saturate(peak(ch) - (k * peak(ch)) / fout);
            end
            else
                lvl[ch] = '0;
        end
        return '{red: lvl[0], green: lvl[1], blue: lvl[2]};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settings = '{max_red: MAX_RESET, max_green: MAX_RESET, max_blue: MAX_RESET,
                         seg_len: SEG_RESET, total_len: TOTAL_RESET,
                         fade_in_len: FADE_IN_RESET, fade_out_len: FADE_OUT_RESET};
            shown = '0;
            dusk_start = '0;
            color_q.delete();
            bad_beats = 0;
            fail_count <= 0;
            beats_due <= 0;
        end
        else
        begin
            // register writes, unknown indexes dropped
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_MAX_RED:   settings.max_red = cfg_data[COLOR_W-1:0];
                    REG_MAX_GREEN: settings.max_green = cfg_data[COLOR_W-1:0];
                    REG_MAX_BLUE:  settings.max_blue = cfg_data[COLOR_W-1:0];
                    REG_SEG_LEN:   settings.seg_len = cfg_data[SEG_W-1:0];
                    REG_TOTAL_LEN: settings.total_len = cfg_data[PERIOD_W-1:0];
                    REG_FADE_IN:   settings.fade_in_len = cfg_data[FADE_W-1:0];
                    REG_FADE_OUT:  settings.fade_out_len = cfg_data[FADE_W-1:0];
                    default: ;
                endcase
            end

            // color beat against the oldest prediction
            if (out_valid && out_ready)
            begin
                got_color = '{red: red, green: green, blue: blue};
                if (color_q.size() == 0)
                begin
                    $display("%0t: color beat r=%0d g=%0d b=%0d with none expected",
                             $time, red, green, blue);
                    bad_beats++;
                end
                else
                begin
                    want_color = color_q.pop_front();
                    if (want_color !== got_color)
                    begin
                        bad_beats++;
                        if (want_color.red !== got_color.red)
                            $display("%0t: red expected %0d got %0d",
                                     $time, want_color.red, got_color.red);
                        if (want_color.green !== got_color.green)
                            $display("%0t: green expected %0d got %0d",
                                     $time, want_color.green, got_color.green);
                        if (want_color.blue !== got_color.blue)
                            $display("%0t: blue expected %0d got %0d",
                                     $time, want_color.blue, got_color.blue);
                    end
                end
            end

            // command beat: predict and update the shown color
            if (in_valid && in_ready)
            begin
                case (command)
                    CMD_SUNRISE: want_color = dawn_color(int'(period));
                    CMD_SUNSET:
                    begin
                        if (period == '0)
                            dusk_start = shown;
                        want_color = dusk_color(int'(period));
                    end
                    CMD_ON:  want_color = full_color();
                    default: want_color = '0;
                endcase
                shown = want_color;
                color_q.push_back(want_color);
            end

            fail_count <= bad_beats;
            beats_due <= color_q.size();
        end
    end

endmodule

/* tb/led_color_ramp_test.sv */
// testbench top for the led color ramp: stimulus, idling, watchdog and verdict
module led_color_ramp_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lcr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int RANDOM_BEATS   = 800;
    localparam int STEADY_BEATS   = 100;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [CMD_W-1:0]      command = CMD_OFF;
    logic [PERIOD_W-1:0]   period = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [COLOR_W-1:0]    red;
    logic [COLOR_W-1:0]    green;
    logic [COLOR_W-1:0]    blue;
    int                    fail_count;
    int                    beats_due;

    // no idling once set
    bit steady = 1'b0;
    int beats_sent = 0;

    // effective lengths, zero taken as one, for shaping the sequences
    int seg_now   = SEG_RESET;
    int total_now = TOTAL_RESET;
    int fin_now   = FADE_IN_RESET;
    int fout_now  = FADE_OUT_RESET;

    led_color_ramp DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .period    (period),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

    led_color_ramp_checker ramp_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .period     (period),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .fail_count (fail_count),
        .beats_due  (beats_due)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // one command beat, with an optional idle burst ahead of it
    task automatic send_beat(input logic [CMD_W-1:0] cmd, input int per);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 11);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        period <= per[PERIOD_W-1:0];
        do
            @(posedge clk);
        while (!in_ready);
        beats_sent++;
    endtask

    // stop sending and wait until every color beat is back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (beats_due != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        @(posedge clk);
    endtask

    task automatic load_settings(input int r, input int g, input int b, input int seg,
                                 input int total, input int fin, input int fout);
        write_reg(REG_SPARE, $urandom);
        write_reg(REG_MAX_RED, r);
        write_reg(REG_MAX_GREEN, g);
        write_reg(REG_MAX_BLUE, b);
        write_reg(REG_SEG_LEN, seg);
        write_reg(REG_TOTAL_LEN, total);
        write_reg(REG_FADE_IN, fin);
        write_reg(REG_FADE_OUT, fout);
        cfg_write <= 1'b0;
        seg_now = ((seg & 'h3FFF) == 0) ? 1 : (seg & 'h3FFF);
        total_now = ((total & 'hFFFF) == 0) ? 1 : (total & 'hFFFF);
        fin_now = ((fin & 'hFF) == 0) ? 1 : (fin & 'hFF);
        fout_now = ((fout & 'hFF) == 0) ? 1 : (fout & 'hFF);
    endtask

    // sunrise steps with rising periods, sometimes landing on segment ends
    task automatic dawn_run();
        int span;
        int stride;
        int p;
        int knot_p;
        span = 4 * seg_now + 2;
        stride = span / $urandom_range(6, 18);
        if (stride < 1)
            stride = 1;
        p = ($urandom_range(0, 3) == 0) ? $urandom_range(0, span) : 0;
        while (p <= span && p <= 16'hFFFF)
        begin
            send_beat(CMD_SUNRISE, p);
            if ($urandom_range(0, 3) == 0)
            begin
                knot_p = (p / seg_now + 1) * seg_now - $urandom_range(0, 1);
                p = (knot_p > p) ? knot_p : p + 1;
            end
            else
                p += $urandom_range(1, 2 * stride);
        end
    endtask

    // sunset steps, mostly from period zero, often landing on phase boundaries
    task automatic dusk_run();
        int span;
        int stride;
        int p;
        int mark;
        span = ((total_now > fin_now) ? total_now : fin_now) + 2;
        stride = span / $urandom_range(6, 18);
        if (stride < 1)
            stride = 1;
        // a run without its opening period now and then
        p = ($urandom_range(0, 7) == 0) ? $urandom_range(1, span) : 0;
        while (p <= span && p <= 16'hFFFF)
        begin
            send_beat(CMD_SUNSET, p);
            if ($urandom_range(0, 2) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       mark = fin_now - 1 + $urandom_range(0, 1);
                    1:       mark = HOLD_START - 1 + $urandom_range(0, 1);
                    2:       mark = total_now - fout_now - 1 + $urandom_range(0, 2);
                    default: mark = total_now - 1 + $urandom_range(0, 1);
                endcase
                p = (mark > p) ? mark : p + 1;
            end
            else
                p += $urandom_range(1, 2 * stride);
        end
    endtask

    function automatic int pick_level();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 255;
            2:       return 'h100 | $urandom_range(0, 255);
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic int pick_fade();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 1;
            2:       return 255;
            3:       return $urandom_range(2, 3);
            default: return $urandom_range(1, 255);
        endcase
    endfunction

    // output side: random stall bursts between ready stretches
    initial
    begin : receiver
        int run;
        forever
        begin
            if (!steady && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            out_ready <= 1'b1;
            run = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                              : $urandom_range(1, 12);
            repeat (run) @(posedge clk);
        end
    end

    // ends the run when nothing moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int target;
        int phase_end;
        int seg;
        int total;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: off, on, segment edges, sunset phases, period extremes
        send_beat(CMD_OFF, 0);
        send_beat(CMD_ON, 16'hFFFF);
        send_beat(CMD_SUNRISE, 0);
        send_beat(CMD_SUNRISE, 449);
        send_beat(CMD_SUNRISE, 450);
        send_beat(CMD_SUNRISE, 1349);
        send_beat(CMD_SUNRISE, 1350);
        send_beat(CMD_SUNRISE, 1800);
        send_beat(CMD_SUNSET, 0);
        send_beat(CMD_SUNSET, 19);
        send_beat(CMD_SUNSET, 20);
        send_beat(CMD_SUNSET, 1781);
        send_beat(CMD_SUNSET, 1800);
        send_beat(CMD_SUNSET, 16'hFFFF);
        drain();

        // a maximum below the knots, zero lengths, oversized data, short fade-in
        load_settings(255, 0, 'h1FF, 0, 100, 1, 0);
        send_beat(CMD_SUNRISE, 0);
        send_beat(CMD_SUNRISE, 1);
        send_beat(CMD_SUNRISE, 2);
        send_beat(CMD_SUNRISE, 3);
        send_beat(CMD_SUNRISE, 4);
        send_beat(CMD_SUNSET, 0);
        send_beat(CMD_SUNSET, 1);
        send_beat(CMD_SUNSET, 2);
        send_beat(CMD_SUNSET, 3);
        send_beat(CMD_SUNSET, 99);
        send_beat(CMD_SUNSET, 100);

        // random phases, each under new settings
        target = beats_sent + RANDOM_BEATS;
        while (beats_sent < target)
        begin
            drain();
            case ($urandom_range(0, 6))
                0:       seg = 0;
                1:       seg = 1;
                2:       seg = 16383;
                3:       seg = 16'hFFFF;
                4:       seg = $urandom_range(1, 16383);
                default: seg = $urandom_range(2, 40);
            endcase
            case ($urandom_range(0, 6))
                0:       total = 0;
                1:       total = 1;
                2:       total = 16'hFFFF;
                3:       total = $urandom_range(1, 16'hFFFF);
                default: total = $urandom_range(2, 600);
            endcase
            load_settings(pick_level(), pick_level(), pick_level(), seg, total,
                          pick_fade(), pick_fade());
            phase_end = beats_sent + $urandom_range(60, 140);
            while (beats_sent < phase_end && beats_sent < target)
            begin
                if (beats_sent >= target - STEADY_BEATS)
                    steady = 1'b1;
                case ($urandom_range(0, 5))
                    0, 1, 2: dawn_run();
                    3, 4:    dusk_run();
                    default: send_beat(CMD_W'($urandom_range(0, 3)), $urandom_range(0, 16'hFFFF));
                endcase
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
